FILE: rtl/lsc_pkg.sv
`timescale 1ns / 1ps

package lsc_pkg;

  localparam int unsigned SET_QUEUE_DEPTH = 2;
  localparam int unsigned SQ_CNT_W = $clog2(SET_QUEUE_DEPTH + 1);
  localparam int unsigned SQ_IDX_W = (SET_QUEUE_DEPTH > 1) ? $clog2(SET_QUEUE_DEPTH) : 1;

  localparam logic [7:0] INFO_CTRL     = 8'h02;
  localparam logic [7:0] INFO_ROOM     = 8'h03;
  localparam logic [7:0] INFO_RUN      = 8'h06;
  localparam logic [7:0] CMD_CONN_ACK  = 8'h7A;
  localparam logic [7:0] CMD_CONN_ACK2 = 8'h7B;
  localparam logic [7:0] CMD_INFO_RSP  = 8'h62;
  localparam logic [7:0] CMD_SET_ACK   = 8'h61;

  localparam logic [1:0] PEND_EMPTY = 2'd3;

  typedef enum logic [2:0] {
    PH_DISC   = 3'd0,
    PH_CONN   = 3'd1,
    PH_IDLE   = 3'd2,
    PH_INFO   = 3'd3,
    PH_SETACK = 3'd4
  } lsc_phase_e;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_FRAME = 3'd1,
    OP_SET   = 3'd2,
    OP_CTRL  = 3'd3,
    OP_POLL  = 3'd4
  } lsc_op_e;

  typedef enum logic [1:0] {
    SEND_NONE = 2'd0,
    SEND_CONN = 2'd1,
    SEND_INFO = 2'd2,
    SEND_SET  = 2'd3
  } lsc_send_e;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_CONN_TO = 3'd1,
    ERR_INFO_TO = 3'd2,
    ERR_SET_TO  = 3'd3,
    ERR_CHKSUM  = 3'd4,
    ERR_Q_FULL  = 3'd5
  } lsc_err_e;

  localparam logic [1:0] CFG_RESP_TO     = 2'd0;
  localparam logic [1:0] CFG_CONN_RETRY  = 2'd1;
  localparam logic [1:0] CFG_POLL_ACTIVE = 2'd2;
  localparam logic [1:0] CFG_POLL_OFF    = 2'd3;

  typedef struct packed {
    logic [15:0] resp_to;
    logic [15:0] conn_retry;
    logic [15:0] poll_active;
    logic [15:0] poll_off;
  } lsc_cfg_t;

  localparam lsc_cfg_t CFG_RST = '{
    resp_to:     16'd1000,
    conn_retry:  16'd5000,
    poll_active: 16'd2000,
    poll_off:    16'd10000
  };

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] now_ms;
    logic [7:0]  frame_cmd;
    logic [7:0]  frame_info_type;
    logic        frame_check_ok;
    logic        info_applied;
    logic [7:0]  set_tag;
    logic        set_turns_on;
    logic        unit_power_on;
  } lsc_in_t;

  typedef struct packed {
    lsc_phase_e          phase;
    logic                connected;
    logic [31:0]         req_time;
    logic [31:0]         conn_time;
    logic                conn_due;
    logic [31:0]         poll_time;
    logic                poll_due;
    logic                fast_poll;
    logic                ctrl_wanted;
    logic [1:0]          pend_pos;
    logic [7:0]          awaited_code;
    logic [SQ_CNT_W-1:0] sq_count;
  } lsc_state_t;

  localparam lsc_state_t STATE_RST = '{
    phase:        PH_DISC,
    connected:    1'b0,
    req_time:     32'd0,
    conn_time:    32'd0,
    conn_due:     1'b1,
    poll_time:    32'd0,
    poll_due:     1'b1,
    fast_poll:    1'b0,
    ctrl_wanted:  1'b0,
    pend_pos:     PEND_EMPTY,
    awaited_code: 8'd0,
    sq_count:     '0
  };

  typedef struct packed {
    logic [1:0] send_kind;
    logic [7:0] send_info_code;
    logic [7:0] send_set_tag;
    logic [2:0] phase_now;
    logic       link_up;
    logic [2:0] error_code;
    logic       set_accepted;
    logic       ack_seen;
    logic [2:0] info_mask;
    logic       poll_started;
  } lsc_res_t;

  // set queue entry: turns-on flag over the tag
  typedef struct packed {
    logic       turns_on;
    logic [7:0] tag;
  } lsc_sq_entry_t;

  typedef struct packed {
    logic          push;
    logic          pop;
    lsc_sq_entry_t entry;
  } lsc_sq_ctrl_t;

  function automatic logic [7:0] lsc_info_code(input logic [1:0] pos);
    logic [7:0] code;
    case (pos)
      2'd0:    code = INFO_CTRL;
      2'd1:    code = INFO_ROOM;
      2'd2:    code = INFO_RUN;
      default: code = 8'd0;
    endcase
    return code;
  endfunction

  // wrapping difference against a 16-bit interval
  function automatic logic lsc_elapsed(input logic [31:0] now, input logic [31:0] since,
                                       input logic [15:0] ms);
    logic [31:0] diff;
    diff = now - since;
    return diff >= {16'd0, ms};
  endfunction

endpackage

FILE: rtl/lsc_step.sv
`timescale 1ns / 1ps

module lsc_step (
  input  lsc_pkg::lsc_cfg_t      cfg_i,
  input  lsc_pkg::lsc_state_t    st_i,
  input  lsc_pkg::lsc_in_t       item_i,
  input  lsc_pkg::lsc_sq_entry_t sq_head_i,
  output lsc_pkg::lsc_state_t    st_o,
  output lsc_pkg::lsc_res_t      res_o,
  output lsc_pkg::lsc_sq_ctrl_t  sq_o
);
  import lsc_pkg::*;

  logic        resp_late;
  logic        retry_due;
  logic        poll_late;
  logic [15:0] poll_iv;

  // the three interval compares run in parallel, all against the old state
  assign resp_late = lsc_elapsed(item_i.now_ms, st_i.req_time, cfg_i.resp_to);
  assign retry_due = lsc_elapsed(item_i.now_ms, st_i.conn_time, cfg_i.conn_retry);
  assign poll_iv   = (st_i.fast_poll || item_i.unit_power_on) ? cfg_i.poll_active
                                                              : cfg_i.poll_off;
  assign poll_late = lsc_elapsed(item_i.now_ms, st_i.poll_time, poll_iv);

  always_comb begin
    lsc_state_t s;
    lsc_res_t   r;
    lsc_sq_ctrl_t q;
    s = st_i;
    r = '0;
    q = '0;
    q.entry.tag      = item_i.set_tag;
    q.entry.turns_on = item_i.set_turns_on;

    case (item_i.opcode)
      OP_TICK: begin
        if (s.phase == PH_CONN && resp_late) begin
          s.phase = PH_DISC;
          r.error_code = ERR_CONN_TO;
        end else if (s.phase == PH_INFO && resp_late) begin
          s.phase = PH_IDLE;
          r.error_code = ERR_INFO_TO;
        end else if (s.phase == PH_SETACK && resp_late) begin
          s.phase = PH_IDLE;
          r.error_code = ERR_SET_TO;
        end

        if (s.phase == PH_DISC) begin
          if (s.conn_due || retry_due) begin
            s.conn_due  = 1'b0;
            s.conn_time = item_i.now_ms;
            s.phase     = PH_CONN;
            s.req_time  = item_i.now_ms;
            r.send_kind = SEND_CONN;
          end
        end else if (s.phase == PH_IDLE) begin
          if (s.sq_count != '0) begin
            q.pop       = 1'b1;
            s.sq_count  = s.sq_count - SQ_CNT_W'(1);
            s.phase     = PH_SETACK;
            s.req_time  = item_i.now_ms;
            if (sq_head_i.turns_on) begin
              s.fast_poll = 1'b1;
            end
            r.send_kind    = SEND_SET;
            r.send_set_tag = sq_head_i.tag;
          end else if (s.ctrl_wanted) begin
            s.ctrl_wanted    = 1'b0;
            s.phase          = PH_INFO;
            s.awaited_code   = INFO_CTRL;
            s.req_time       = item_i.now_ms;
            r.send_kind      = SEND_INFO;
            r.send_info_code = INFO_CTRL;
          end else if (s.pend_pos != PEND_EMPTY) begin
            s.phase          = PH_INFO;
            s.awaited_code   = lsc_info_code(s.pend_pos);
            s.req_time       = item_i.now_ms;
            r.send_kind      = SEND_INFO;
            r.send_info_code = lsc_info_code(s.pend_pos);
            s.pend_pos       = s.pend_pos + 2'd1;
          end else if (s.poll_due || poll_late) begin
            // new poll cycle sends the first code of the list straight away
            s.poll_due       = 1'b0;
            s.poll_time      = item_i.now_ms;
            r.poll_started   = 1'b1;
            s.phase          = PH_INFO;
            s.awaited_code   = INFO_CTRL;
            s.req_time       = item_i.now_ms;
            r.send_kind      = SEND_INFO;
            r.send_info_code = INFO_CTRL;
            s.pend_pos       = 2'd1;
          end
        end
      end
      OP_FRAME: begin
        if (!item_i.frame_check_ok) begin
          r.error_code = ERR_CHKSUM;
        end else if (item_i.frame_cmd == CMD_CONN_ACK || item_i.frame_cmd == CMD_CONN_ACK2) begin
          if (s.phase == PH_CONN) begin
            s.connected = 1'b1;
            s.phase     = PH_IDLE;
            s.fast_poll = 1'b1;
            s.poll_due  = 1'b1;
            s.pend_pos  = 2'd0;
          end
        end else if (item_i.frame_cmd == CMD_INFO_RSP) begin
          if (s.phase == PH_INFO) begin
            if (item_i.info_applied) begin
              if (item_i.frame_info_type == INFO_CTRL) begin
                r.info_mask = 3'b001;
              end else if (item_i.frame_info_type == INFO_ROOM) begin
                r.info_mask = 3'b010;
              end else if (item_i.frame_info_type == INFO_RUN) begin
                r.info_mask = 3'b100;
              end
            end
            if (s.awaited_code == INFO_CTRL) begin
              s.fast_poll = 1'b0;
            end
            s.phase = PH_IDLE;
          end
        end else if (item_i.frame_cmd == CMD_SET_ACK) begin
          if (s.phase == PH_SETACK) begin
            r.ack_seen = 1'b1;
            s.phase    = PH_IDLE;
            s.poll_due = 1'b1;
          end
        end
      end
      OP_SET: begin
        if (s.sq_count < SQ_CNT_W'(SET_QUEUE_DEPTH)) begin
          q.push         = 1'b1;
          s.sq_count     = s.sq_count + SQ_CNT_W'(1);
          r.set_accepted = 1'b1;
        end else begin
          r.error_code = ERR_Q_FULL;
        end
      end
      OP_CTRL: begin
        s.ctrl_wanted = 1'b1;
      end
      OP_POLL: begin
        if (s.connected) begin
          s.pend_pos = 2'd0;
        end
      end
      default: begin
      end
    endcase

    r.phase_now = s.phase;
    r.link_up   = s.connected;
    st_o  = s;
    res_o = r;
    sq_o  = q;
  end

endmodule

FILE: rtl/link_session_controller_core.sv
`timescale 1ns / 1ps

// Session controller for a request/acknowledge link. Each input transaction
// (tick, frame summary, set request, control-info request, full poll) gives
// exactly one output transaction saying what to send next plus any timeout,
// error or acknowledgement.
// Input channel: in_valid_i / in_stall_o, fields opcode_i .. unit_power_on_i.
// Output channel: out_valid_o / out_stall_i, fields send_kind_o .. poll_started_o.
// Config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 response
// timeout, 1 connect retry, 2 active poll, 3 off poll). The user must write
// only while idle; the block itself does not enforce it. An accepted item is held
// in the input register; its result enters the output register when it advances.
// Throughput: one item per cycle while the output is not stalled; the session state
// update is a single pass of compare-and-select logic between the input and output
// registers. A stalled result holds the output register; the input register still
// takes one more transaction, then in_stall_o rises until the output drains.
// Reset: phase disconnected, link down, connect and poll due at once,
// set queue empty, registers at their default intervals.
module link_session_controller_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] now_ms_i,
  input  logic [7:0]  frame_cmd_i,
  input  logic [7:0]  frame_info_type_i,
  input  logic        frame_check_ok_i,
  input  logic        info_applied_i,
  input  logic [7:0]  set_tag_i,
  input  logic        set_turns_on_i,
  input  logic        unit_power_on_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  send_kind_o,
  output logic [7:0]  send_info_code_o,
  output logic [7:0]  send_set_tag_o,
  output logic [2:0]  phase_now_o,
  output logic        link_up_o,
  output logic [2:0]  error_code_o,
  output logic        set_accepted_o,
  output logic        ack_seen_o,
  output logic [2:0]  info_mask_o,
  output logic        poll_started_o
);
  import lsc_pkg::*;

  lsc_cfg_t      cfg_q;
  lsc_in_t       in_q;
  logic          in_valid_q;
  lsc_state_t    st_q, st_d;
  lsc_res_t      res_q, res_d;
  logic          out_valid_q;
  lsc_sq_ctrl_t  sq_ctrl;
  lsc_sq_entry_t sq_q [SET_QUEUE_DEPTH];
  logic          in_take;
  logic          advance;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RESP_TO:     cfg_q.resp_to     <= cfg_wdata_i;
        CFG_CONN_RETRY:  cfg_q.conn_retry  <= cfg_wdata_i;
        CFG_POLL_ACTIVE: cfg_q.poll_active <= cfg_wdata_i;
        CFG_POLL_OFF:    cfg_q.poll_off    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= STATE_RST;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.opcode          <= opcode_i;
      in_q.now_ms          <= now_ms_i;
      in_q.frame_cmd       <= frame_cmd_i;
      in_q.frame_info_type <= frame_info_type_i;
      in_q.frame_check_ok  <= frame_check_ok_i;
      in_q.info_applied    <= info_applied_i;
      in_q.set_tag         <= set_tag_i;
      in_q.set_turns_on    <= set_turns_on_i;
      in_q.unit_power_on   <= unit_power_on_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // set queue: head at entry 0, shifted down on a pop
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (sq_ctrl.pop) begin
        for (int i = 0; i < SET_QUEUE_DEPTH - 1; i++) begin
          sq_q[i] <= sq_q[i+1];
        end
      end
      if (sq_ctrl.push) begin
        sq_q[st_q.sq_count[SQ_IDX_W-1:0]] <= sq_ctrl.entry;
      end
    end
  end

  lsc_step u_step (
    .cfg_i     (cfg_q),
    .st_i      (st_q),
    .item_i    (in_q),
    .sq_head_i (sq_q[0]),
    .st_o      (st_d),
    .res_o     (res_d),
    .sq_o      (sq_ctrl)
  );

  assign out_valid_o      = out_valid_q;
  assign send_kind_o      = res_q.send_kind;
  assign send_info_code_o = res_q.send_info_code;
  assign send_set_tag_o   = res_q.send_set_tag;
  assign phase_now_o      = res_q.phase_now;
  assign link_up_o        = res_q.link_up;
  assign error_code_o     = res_q.error_code;
  assign set_accepted_o   = res_q.set_accepted;
  assign ack_seen_o       = res_q.ack_seen;
  assign info_mask_o      = res_q.info_mask;
  assign poll_started_o   = res_q.poll_started;

  a_sq_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.sq_count <= SQ_CNT_W'(SET_QUEUE_DEPTH))
    else $error("set queue count beyond depth");

  a_link_never_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.connected |-> (st_q.phase != PH_DISC && st_q.phase != PH_CONN))
    else $error("connected session back in a connect phase");

  a_advance_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("processed transaction produced no result");

  a_set_send_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && send_kind_o == SEND_SET) |-> (phase_now_o == PH_SETACK))
    else $error("set command sent without awaiting its ack");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned LATENCY     = 2;

  // Expected session behaviour, kept in step with every accepted input transaction.
  class link_session_tracker;
    logic [15:0]   resp_to, conn_retry, poll_active, poll_off;
    lsc_phase_e    phase;
    bit            connected, conn_due, poll_due, fast_poll, ctrl_wanted;
    logic [31:0]   req_time, conn_time, poll_time;
    int            pend_pos;
    logic [7:0]    awaited;
    lsc_sq_entry_t sq [SET_QUEUE_DEPTH];
    int            sq_count;
    lsc_res_t      due_replies [$];
    int            errors, n_checked, n_timeouts, n_acks, n_polls;
    int            op_seen [8];

    function new();
      resp_to     = 16'd1000;
      conn_retry  = 16'd5000;
      poll_active = 16'd2000;
      poll_off    = 16'd10000;
      phase       = PH_DISC;
      connected   = 1'b0;
      conn_due    = 1'b1;
      poll_due    = 1'b1;
      fast_poll   = 1'b0;
      ctrl_wanted = 1'b0;
      req_time    = '0;
      conn_time   = '0;
      poll_time   = '0;
      pend_pos    = PEND_EMPTY;
      awaited     = '0;
      sq_count    = 0;
      foreach (sq[i]) sq[i] = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] v);
      case (idx)
        CFG_RESP_TO:     resp_to = v;
        CFG_CONN_RETRY:  conn_retry = v;
        CFG_POLL_ACTIVE: poll_active = v;
        default:         poll_off = v;
      endcase
    endfunction

    function bit gone(logic [31:0] now, logic [31:0] since, logic [15:0] ms);
      logic [31:0] d;
      d = now - since;
      return d >= {16'd0, ms};
    endfunction

    function void issue_info(logic [31:0] now, logic [7:0] code, inout lsc_res_t r);
      phase            = PH_INFO;
      awaited          = code;
      req_time         = now;
      r.send_kind      = SEND_INFO;
      r.send_info_code = code;
    endfunction

    function bit next_pending(logic [31:0] now, inout lsc_res_t r);
      logic [7:0] codes [3];
      codes = '{INFO_CTRL, INFO_ROOM, INFO_RUN};
      if (pend_pos >= PEND_EMPTY) begin
        pend_pos = PEND_EMPTY;
        return 1'b0;
      end
      issue_info(now, codes[pend_pos], r);
      pend_pos++;
      return 1'b1;
    endfunction

    function lsc_res_t predict_reply(lsc_in_t ev);
      lsc_res_t    r;
      logic [15:0] iv;
      logic [31:0] now;
      r   = '0;
      now = ev.now_ms;
      case (ev.opcode)
        OP_TICK: begin
          // timeout of the current wait first, then the action of the resulting phase
          if (phase == PH_CONN && gone(now, req_time, resp_to)) begin
            phase = PH_DISC;
            r.error_code = ERR_CONN_TO;
          end else if (phase == PH_INFO && gone(now, req_time, resp_to)) begin
            phase = PH_IDLE;
            r.error_code = ERR_INFO_TO;
          end else if (phase == PH_SETACK && gone(now, req_time, resp_to)) begin
            phase = PH_IDLE;
            r.error_code = ERR_SET_TO;
          end
          if (phase == PH_DISC) begin
            if (conn_due || gone(now, conn_time, conn_retry)) begin
              conn_due    = 1'b0;
              conn_time   = now;
              phase       = PH_CONN;
              req_time    = now;
              r.send_kind = SEND_CONN;
            end
          end else if (phase == PH_IDLE) begin
            if (sq_count > 0) begin
              r.send_kind    = SEND_SET;
              r.send_set_tag = sq[0].tag;
              if (sq[0].turns_on) fast_poll = 1'b1;
              for (int i = 1; i < SET_QUEUE_DEPTH; i++) sq[i-1] = sq[i];
              sq_count--;
              phase    = PH_SETACK;
              req_time = now;
            end else if (ctrl_wanted) begin
              ctrl_wanted = 1'b0;
              issue_info(now, INFO_CTRL, r);
            end else if (!next_pending(now, r)) begin
              iv = (fast_poll || ev.unit_power_on) ? poll_active : poll_off;
              if (poll_due || gone(now, poll_time, iv)) begin
                pend_pos       = 0;
                poll_due       = 1'b0;
                poll_time      = now;
                r.poll_started = 1'b1;
                void'(next_pending(now, r));
              end
            end
          end
        end
        OP_FRAME: begin
          if (!ev.frame_check_ok) begin
            r.error_code = ERR_CHKSUM;
          end else if (ev.frame_cmd == CMD_CONN_ACK || ev.frame_cmd == CMD_CONN_ACK2) begin
            if (phase == PH_CONN) begin
              connected = 1'b1;
              phase     = PH_IDLE;
              fast_poll = 1'b1;
              poll_due  = 1'b1;
              pend_pos  = 0;
            end
          end else if (ev.frame_cmd == CMD_INFO_RSP) begin
            if (phase == PH_INFO) begin
              if (ev.info_applied) begin
                if (ev.frame_info_type == INFO_CTRL) r.info_mask = 3'b001;
                else if (ev.frame_info_type == INFO_ROOM) r.info_mask = 3'b010;
                else if (ev.frame_info_type == INFO_RUN) r.info_mask = 3'b100;
              end
              if (awaited == INFO_CTRL) fast_poll = 1'b0;
              phase = PH_IDLE;
            end
          end else if (ev.frame_cmd == CMD_SET_ACK) begin
            if (phase == PH_SETACK) begin
              r.ack_seen = 1'b1;
              phase      = PH_IDLE;
              poll_due   = 1'b1;
            end
          end
        end
        OP_SET: begin
          if (sq_count < SET_QUEUE_DEPTH) begin
            sq[sq_count] = '{turns_on: ev.set_turns_on, tag: ev.set_tag};
            sq_count++;
            r.set_accepted = 1'b1;
          end else begin
            r.error_code = ERR_Q_FULL;
          end
        end
        OP_CTRL: ctrl_wanted = 1'b1;
        OP_POLL: if (connected) pend_pos = 0;
        default: ;
      endcase
      r.phase_now = phase;
      r.link_up   = connected;
      return r;
    endfunction

    function void note_event(lsc_in_t ev);
      lsc_res_t r;
      r = predict_reply(ev);
      due_replies.push_back(r);
      op_seen[ev.opcode]++;
      if (r.error_code == ERR_CONN_TO || r.error_code == ERR_INFO_TO ||
          r.error_code == ERR_SET_TO) n_timeouts++;
      if (r.ack_seen) n_acks++;
      if (r.poll_started) n_polls++;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH reply %0d: %s", n_checked, what);
    endtask

    task cmp(string nm, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", nm, got, want));
    endtask

    task check_reply(lsc_res_t got);
      lsc_res_t want;
      if (due_replies.size() == 0) begin
        report("reply with no transaction outstanding");
        return;
      end
      want = due_replies.pop_front();
      cmp("send_kind", 8'(got.send_kind), 8'(want.send_kind));
      cmp("send_info_code", got.send_info_code, want.send_info_code);
      cmp("send_set_tag", got.send_set_tag, want.send_set_tag);
      cmp("phase_now", 8'(got.phase_now), 8'(want.phase_now));
      cmp("link_up", 8'(got.link_up), 8'(want.link_up));
      cmp("error_code", 8'(got.error_code), 8'(want.error_code));
      cmp("set_accepted", 8'(got.set_accepted), 8'(want.set_accepted));
      cmp("ack_seen", 8'(got.ack_seen), 8'(want.ack_seen));
      cmp("info_mask", 8'(got.info_mask), 8'(want.info_mask));
      cmp("poll_started", 8'(got.poll_started), 8'(want.poll_started));
      n_checked++;
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  opcode_i = '0;
  logic [31:0] now_ms_i = '0;
  logic [7:0]  frame_cmd_i = '0;
  logic [7:0]  frame_info_type_i = '0;
  logic        frame_check_ok_i = 1'b0;
  logic        info_applied_i = 1'b0;
  logic [7:0]  set_tag_i = '0;
  logic        set_turns_on_i = 1'b0;
  logic        unit_power_on_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  send_kind_o;
  logic [7:0]  send_info_code_o;
  logic [7:0]  send_set_tag_o;
  logic [2:0]  phase_now_o;
  logic        link_up_o;
  logic [2:0]  error_code_o;
  logic        set_accepted_o;
  logic        ack_seen_o;
  logic [2:0]  info_mask_o;
  logic        poll_started_o;

  link_session_tracker trk;
  lsc_res_t    reply_seen;
  logic [31:0] clock_ms = '0;
  bit          send_quiet = 1'b0;
  bit          recv_quiet = 1'b0;
  bit          hold_go = 1'b0;
  logic        hold_on = 1'b0;
  int unsigned cycles = 0;
  int          n_settings = 1;

  link_session_controller_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .now_ms_i          (now_ms_i),
    .frame_cmd_i       (frame_cmd_i),
    .frame_info_type_i (frame_info_type_i),
    .frame_check_ok_i  (frame_check_ok_i),
    .info_applied_i    (info_applied_i),
    .set_tag_i         (set_tag_i),
    .set_turns_on_i    (set_turns_on_i),
    .unit_power_on_i   (unit_power_on_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .send_kind_o       (send_kind_o),
    .send_info_code_o  (send_info_code_o),
    .send_set_tag_o    (send_set_tag_o),
    .phase_now_o       (phase_now_o),
    .link_up_o         (link_up_o),
    .error_code_o      (error_code_o),
    .set_accepted_o    (set_accepted_o),
    .ack_seen_o        (ack_seen_o),
    .info_mask_o       (info_mask_o),
    .poll_started_o    (poll_started_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  assign reply_seen = {send_kind_o, send_info_code_o, send_set_tag_o, phase_now_o, link_up_o,
                       error_code_o, set_accepted_o, ack_seen_o, info_mask_o, poll_started_o};

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) trk.check_reply(reply_seen);
  end

  always @(posedge clk_i) begin
    out_stall_i <= hold_on || (!recv_quiet && ($urandom_range(0, 99) < 8));
  end

  // long receiver hold-off so the pipeline fills and the input side stalls
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("cycle limit reached with %0d replies outstanding", trk.due_replies.size());
    $display("link_session_controller_core test failed");
    $finish;
  end

  function automatic lsc_in_t ev_of(logic [2:0] op, logic [31:0] now);
    lsc_in_t     ev;
    logic [63:0] raw;
    raw       = {$urandom, $urandom};
    ev        = raw[$bits(lsc_in_t)-1:0];
    ev.opcode = op;
    ev.now_ms = now;
    return ev;
  endfunction

  function automatic lsc_in_t frame_of(logic [31:0] now, logic [7:0] cmd, logic [7:0] itype,
                                       logic ok, logic applied);
    lsc_in_t ev;
    ev                 = ev_of(OP_FRAME, now);
    ev.frame_cmd       = cmd;
    ev.frame_info_type = itype;
    ev.frame_check_ok  = ok;
    ev.info_applied    = applied;
    return ev;
  endfunction

  // Mostly a well-behaved appliance answering what the controller last sent,
  // with some noise and out-of-phase frames mixed in.
  function automatic lsc_in_t random_event();
    lsc_in_t    ev;
    int         pick;
    int         sub;
    logic [7:0] cmds [4];
    cmds = '{CMD_CONN_ACK, CMD_CONN_ACK2, CMD_INFO_RSP, CMD_SET_ACK};
    if ($urandom_range(0, 9) == 0) clock_ms += $urandom_range(0, 80000);
    else clock_ms += $urandom_range(0, 400);
    pick = $urandom_range(0, 99);
    sub  = $urandom_range(0, 19);
    ev   = ev_of(OP_TICK, clock_ms);
    if (pick < 12) begin
      ev.opcode = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0) ev.now_ms = $urandom;
      return ev;
    end
    case (trk.phase)
      PH_CONN: begin
        if (pick < 70) ev = frame_of(clock_ms, $urandom_range(0, 1) ? CMD_CONN_ACK : CMD_CONN_ACK2,
                                     ev.frame_info_type, $urandom_range(0, 9) != 0, 1'b1);
      end
      PH_INFO: begin
        if (pick < 70) begin
          ev = frame_of(clock_ms, CMD_INFO_RSP, ev.frame_info_type,
                        $urandom_range(0, 9) != 0, $urandom_range(0, 4) != 0);
          if ($urandom_range(0, 4) != 0) ev.frame_info_type = trk.awaited;
        end else if (sub < 3) begin
          ev.opcode = OP_SET;
        end
      end
      PH_SETACK: begin
        if (pick < 65) ev = frame_of(clock_ms, CMD_SET_ACK, ev.frame_info_type,
                                     $urandom_range(0, 9) != 0, ev.info_applied);
        else if (sub < 6) ev.opcode = OP_SET;
      end
      default: begin
        if (sub < 11) ev.opcode = OP_TICK;
        else if (sub < 15) ev.opcode = OP_SET;
        else if (sub < 17) ev.opcode = OP_CTRL;
        else if (sub < 19) ev.opcode = OP_POLL;
        else ev = frame_of(clock_ms, cmds[$urandom_range(0, 3)], ev.frame_info_type,
                           1'b1, ev.info_applied);
      end
    endcase
    return ev;
  endfunction

  task automatic send_event(input lsc_in_t ev);
    opcode_i          <= ev.opcode;
    now_ms_i          <= ev.now_ms;
    frame_cmd_i       <= ev.frame_cmd;
    frame_info_type_i <= ev.frame_info_type;
    frame_check_ok_i  <= ev.frame_check_ok;
    info_applied_i    <= ev.info_applied;
    set_tag_i         <= ev.set_tag;
    set_turns_on_i    <= ev.set_turns_on;
    unit_power_on_i   <= ev.unit_power_on;
    in_valid_i        <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    trk.note_event(ev);
    if (!send_quiet && $urandom_range(0, 99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic run_random(input int n);
    repeat (n) send_event(random_event());
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (trk.due_replies.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic program_intervals(input logic [15:0] resp, input logic [15:0] retry,
                                   input logic [15:0] active, input logic [15:0] off);
    logic [15:0] vals [4];
    vals = '{resp, retry, active, off};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= i[1:0];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      trk.set_reg(i[1:0], vals[i]);
    end
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  initial begin
    lsc_in_t ev;
    trk = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk through the session at reset intervals
    send_event(ev_of(OP_POLL, 32'd0));      // full poll before link up is ignored
    send_event(ev_of(OP_TICK, 32'd0));      // connect due at once
    send_event(frame_of(32'd0, CMD_CONN_ACK, 8'hFF, 1'b0, 1'b1));
    send_event(frame_of(32'd0, CMD_INFO_RSP, INFO_CTRL, 1'b1, 1'b1));
    send_event(ev_of(OP_TICK, 32'd1000));   // connect timeout
    send_event(ev_of(OP_TICK, 32'd5000));   // retry spacing reached
    send_event(frame_of(32'd5000, CMD_CONN_ACK2, 8'h00, 1'b1, 1'b0));
    ev = ev_of(OP_SET, 32'd5001);
    ev.set_tag = 8'hFF;
    ev.set_turns_on = 1'b1;
    send_event(ev);
    ev.set_tag = 8'h00;
    ev.set_turns_on = 1'b0;
    send_event(ev);
    ev.set_tag = 8'h5A;
    send_event(ev);                         // queue full
    send_event(ev_of(OP_TICK, 32'd5002));
    send_event(frame_of(32'd5002, CMD_SET_ACK, 8'h00, 1'b1, 1'b0));
    send_event(ev_of(OP_TICK, 32'd5003));
    send_event(ev_of(OP_TICK, 32'd6003));   // set timeout and info request on one tick
    send_event(frame_of(32'd6003, CMD_INFO_RSP, INFO_CTRL, 1'b1, 1'b1));
    send_event(ev_of(OP_CTRL, 32'd6004));
    send_event(ev_of(OP_TICK, 32'd6005));
    send_event(ev_of(OP_TICK, 32'd7005));   // info timeout, next code follows
    send_event(frame_of(32'd7005, CMD_INFO_RSP, INFO_ROOM, 1'b1, 1'b0));
    send_event(ev_of(OP_TICK, 32'd7006));
    send_event(frame_of(32'd7006, CMD_INFO_RSP, INFO_RUN, 1'b1, 1'b1));
    send_event(ev_of(OP_TICK, 32'd7007));   // list empty, poll due
    send_event(frame_of(32'd7007, 8'hFF, 8'hFF, 1'b1, 1'b1));
    send_event(ev_of(OP_POLL, 32'd7008));
    send_event(ev_of(3'd7, 32'hFFFF_FFFF)); // unused opcode
    send_event(ev_of(OP_TICK, 32'hFFFF_FFFF));

    clock_ms = 32'h0001_0000;
    run_random(300);

    settle();
    program_intervals(16'd1, 16'd1, 16'd1, 16'd1);
    send_quiet = 1'b1;
    recv_quiet = 1'b1;
    run_random(300);
    send_quiet = 1'b0;
    recv_quiet = 1'b0;

    settle();
    program_intervals(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    clock_ms = 32'hFFFE_0000;               // run through the 32-bit wrap
    run_random(250);

    settle();
    program_intervals(16'd0, 16'd0, 16'd0, 16'd0);
    run_random(150);

    settle();
    program_intervals(16'($urandom_range(200, 1500)), 16'($urandom_range(500, 4000)),
                      16'($urandom_range(300, 3000)), 16'($urandom_range(1000, 9000)));
    hold_go = 1'b1;
    send_quiet = 1'b1;
    run_random(350);
    send_quiet = 1'b0;

    settle();
    if (trk.due_replies.size() != 0) trk.report("replies still outstanding at end");
    $display("Covered %0d ticks, %0d frames, %0d set, %0d control-info, %0d poll requests",
             trk.op_seen[OP_TICK], trk.op_seen[OP_FRAME], trk.op_seen[OP_SET],
             trk.op_seen[OP_CTRL], trk.op_seen[OP_POLL]);
    $display("over %0d interval settings: %0d replies, %0d timeouts, %0d set acks, %0d polls",
             n_settings, trk.n_checked, trk.n_timeouts, trk.n_acks, trk.n_polls);
    if (trk.errors == 0) begin
      $display("link_session_controller_core test passed");
    end else begin
      $display("link_session_controller_core test failed");
    end
    $finish;
  end

endmodule
